FILE: sv/utf8_byte_decoder_unit_assert.svh
// Assertion macros used by the checker file of the UTF-8 decoder.
`ifndef UTF8_BYTE_DECODER_UNIT_ASSERT_SVH
`define UTF8_BYTE_DECODER_UNIT_ASSERT_SVH

// Concurrent assertion on the rising clock, switched off while reset is held.
`define UBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Concurrent assertion on the rising clock that also holds during reset.
`define UBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: sv/ubd_pkg.sv
package ubd_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int CODE_W = 21;
    localparam int PEND_W = 2;

    // Replacement code after reset (U+FFFD).
    localparam logic [CODE_W-1:0] REPL_RESET = 21'h00FFFD;

    // Byte class limits.
    localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;

    // One decoded result.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              rep;
    } result_t;

    // Everything one byte produces: up to two results and the next state.
    typedef struct packed {
        logic [1:0]        num;
        result_t           r0;
        result_t           r1;
        logic [PEND_W-1:0] pend;
        logic [CODE_W-1:0] partial;
    } step_t;

    // Results of one byte as held in the output queue.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } group_t;

endpackage

FILE: sv/ubd_step.sv
module ubd_step (
    input  logic [ubd_pkg::BYTE_W-1:0] byte_value,
    input  logic                       final_byte,
    input  logic [ubd_pkg::PEND_W-1:0] pend,
    input  logic [ubd_pkg::CODE_W-1:0] partial,
    input  logic [ubd_pkg::CODE_W-1:0] repl_code,
    output ubd_pkg::step_t             step
);

    logic [ubd_pkg::CODE_W-1:0] shifted;

    // Partial code with the six payload bits of a continuation byte shifted in.
    assign shifted = {partial[ubd_pkg::CODE_W-7:0], byte_value[5:0]};

    // Classify the byte and work out its results and the next state.
    always_comb begin
        step.num     = 2'd0;
        step.r0      = '{code: repl_code, rep: 1'b1};
        step.r1      = '{code: {13'b0, byte_value}, rep: 1'b0};
        step.pend    = pend;
        step.partial = partial;
        if (byte_value inside {[8'h00:ubd_pkg::ASCII_MAX]}) begin
            // An ASCII byte that cuts a sequence short comes after a replacement.
            if (pend != 2'd0) begin
                step.num = 2'd2;
            end else begin
                step.num = 2'd1;
                step.r0  = '{code: {13'b0, byte_value}, rep: 1'b0};
            end
            step.pend = 2'd0;
        end else if (byte_value inside {[8'h80:ubd_pkg::CONT_MAX]}) begin
            if (pend != 2'd0) begin
                step.partial = shifted;
                step.pend    = pend - 2'd1;
                if (pend == 2'd1) begin
                    step.num = 2'd1;
                    step.r0  = '{code: shifted, rep: 1'b0};
                end
            end else begin
                // Stray continuation byte.
                step.num = 2'd1;
            end
        end else if (byte_value inside {[8'hC0:ubd_pkg::LEAD2_MAX]}) begin
            step.pend    = 2'd1;
            step.partial = {16'b0, byte_value[4:0]};
        end else if (byte_value inside {[8'hE0:ubd_pkg::LEAD3_MAX]}) begin
            step.pend    = 2'd2;
            step.partial = {17'b0, byte_value[3:0]};
        end else if (byte_value inside {[8'hF0:ubd_pkg::LEAD4_MAX]}) begin
            step.pend    = 2'd3;
            step.partial = {18'b0, byte_value[2:0]};
        end else begin
            // Invalid byte F8 to FF.
            step.num  = 2'd1;
            step.pend = 2'd0;
        end

        // End of text: a sequence still open is reported, and the state clears.
        // A sequence can only remain open when this byte emitted nothing.
        if (final_byte) begin
            if (step.pend != 2'd0) begin
                step.num = 2'd1;
                step.r0  = '{code: repl_code, rep: 1'b1};
            end
            step.pend    = 2'd0;
            step.partial = '0;
        end
    end

endmodule

FILE: sv/utf8_byte_decoder_unit.sv
// UTF-8 byte decoder: takes one byte per request on the s_ stream (tlast marks the
// last byte of a text) and returns code points on the m_ stream, with tuser set on
// replacement results and tlast on the last result of each byte. A new byte is
// taken every cycle while the queue has room; a result passes through the input
// register and the queue before it leaves. A byte that yields two results (ASCII
// cutting a sequence short) holds the output port for both; results leave at one
// per cycle while m_tready is high, from a two-entry queue of per-byte groups. The
// replacement code is written via cfg_wr_en and cfg_wr_data and resets to U+FFFD.
module utf8_byte_decoder_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Configuration: replacement code.
    input  logic                       cfg_wr_en,
    input  logic [ubd_pkg::CODE_W-1:0] cfg_wr_data,
    // Input bytes.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,    // [7:0] byte_value
    input  logic                       s_tlast,    // final_byte
    // Results.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,    // [20:0] code_point, [23:21] zero
    output logic                       m_tuser,    // is_replacement
    output logic                       m_tlast     // last_of_run
);

    logic [ubd_pkg::CODE_W-1:0] repl_reg;
    logic [ubd_pkg::PEND_W-1:0] pend_reg;
    logic [ubd_pkg::CODE_W-1:0] partial_reg;
    logic                       in_vld_reg;
    logic [ubd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_fin_reg;
    ubd_pkg::group_t            grp_reg [2];
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    logic                       sub_reg;

    ubd_pkg::step_t             step;
    ubd_pkg::group_t            head;
    ubd_pkg::result_t           cur;
    logic                       proc;
    logic                       push;
    logic                       out_fire;
    logic                       head_last;
    logic                       pop;

    // Replacement code register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg <= ubd_pkg::REPL_RESET;
        end else if (cfg_wr_en) begin
            repl_reg <= cfg_wr_data;
        end
    end

    // Decode of the registered byte.
    ubd_step u_step (
        .byte_value (in_byte_reg),
        .final_byte (in_fin_reg),
        .pend       (pend_reg),
        .partial    (partial_reg),
        .repl_code  (repl_reg),
        .step       (step)
    );

    // Output side of the queue.
    assign head      = grp_reg[rd_ptr_reg];
    assign cur       = sub_reg ? head.r1 : head.r0;
    assign head_last = sub_reg || !head.two;
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign m_tdata   = {3'b0, cur.code};
    assign m_tuser   = cur.rep;
    assign m_tlast   = head_last;
    assign out_fire  = m_tvalid && m_tready;
    assign pop       = out_fire && head_last;

    // A registered byte is decoded once the queue has room for its group.
    assign proc     = in_vld_reg && ((cnt_reg != 2'd2) || pop);
    assign push     = proc && (step.num != 2'd0);
    assign s_tready = !in_vld_reg || proc;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_fin_reg  <= s_tlast;
        end
    end

    // Decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            partial_reg <= '0;
        end else if (proc) begin
            pend_reg    <= step.pend;
            partial_reg <= step.partial;
        end
    end

    // Queue control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            sub_reg    <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 1'b0;
            end else if (out_fire) begin
                sub_reg    <= 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            grp_reg[wr_ptr_reg] <= '{two: step.num[1], r0: step.r0, r1: step.r1};
        end
    end

endmodule

FILE: sv/ubd_checker.sv
`include "utf8_byte_decoder_unit_assert.svh"

module ubd_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tuser,
    input logic m_tlast
);

    // A stalled result stays offered.
    `UBD_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "stalled result was withdrawn")

    // The first of two results from one byte is always a replacement.
    `UBD_ASSERT(a_first_rep, m_tvalid && !m_tlast |-> m_tuser, "leading result not a replacement")

    // The second result of a byte follows right after the first.
    `UBD_ASSERT(a_pair, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "second result missing")

    // No result appears right after reset.
    `UBD_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_tvalid, "result offered after reset")

endmodule

bind utf8_byte_decoder_unit ubd_checker u_ubd_checker (.*);
